@@ hw/rtl/eul_pkg.sv @@
// shared types, constants and fixed-point helpers for the euler angle to rotation matrix block
package eul_pkg;

    // field and word widths
    localparam int FIELD_W     = 16;
    localparam int IN_FIELDS   = 3;
    localparam int OUT_FIELDS  = 9;
    localparam int IN_DATA_W   = IN_FIELDS * FIELD_W;
    localparam int OUT_DATA_W  = OUT_FIELDS * FIELD_W;

    // angle and fraction formats, defaults for the top level parameters
    localparam int ANGLE_BITS  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int PHASE_BITS  = 32;
    localparam int Q_BITS      = 30;

    // cordic datapath
    localparam int EUL_LANES    = 3;
    localparam int LANE_ROLL    = 0;
    localparam int LANE_PITCH   = 1;
    localparam int LANE_YAW     = 2;
    localparam int DW           = 32;
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [DW-1:0] CORDIC_X0 = 32'sd652032874;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic signed [DW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1
    };

    // one angle in flight through the cordic chain
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic                 flip;
    } t_lane;

    typedef t_lane [EUL_LANES-1:0] t_lanes;

    // sine and cosine of one angle, q30
    typedef struct packed {
        logic signed [DW-1:0] sin;
        logic signed [DW-1:0] cos;
    } t_trig;

    typedef t_trig [EUL_LANES-1:0] t_trigs;

    // q60 product rounded to q30, ties away from zero
    function automatic logic signed [DW-1:0] eul_rnd_q30(input logic signed [2*DW-1:0] p);
        logic [2*DW-1:0] mag;
        logic [2*DW-1:0] m;
        mag = p[2*DW-1] ? 64'(-p) : 64'(p);
        m   = (mag + (64'(1) << (Q_BITS - 1))) >> Q_BITS;
        return p[2*DW-1] ? -$signed(32'(m)) : $signed(32'(m));
    endfunction

    // q30 sum rounded to q(frac), ties away from zero, clamped to unit magnitude
    function automatic logic [FIELD_W-1:0] eul_quant(input logic signed [DW:0] v,
                                                     input int frac);
        logic signed [DW+1:0] vx;
        logic        [DW+1:0] mag;
        logic        [DW+1:0] m;
        logic signed [DW+2:0] r;
        logic signed [DW+2:0] lim;
        int                   qs;
        qs  = Q_BITS - frac;
        vx  = 34'(v);
        mag = vx[DW+1] ? 34'(-vx) : 34'(vx);
        if (qs == 0) begin
            m = mag;
        end else begin
            m = (mag + (34'(1) << (qs - 1))) >> qs;
        end
        r   = vx[DW+1] ? -$signed(35'(m)) : $signed(35'(m));
        lim = $signed(35'(1) << frac);
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r[FIELD_W-1:0];
    endfunction

endpackage

@@ hw/rtl/eul_fold.sv @@
// input stage: turns the three binary angles into folded cordic start values
module eul_fold
    import eul_pkg::*;
#(
    parameter int ANGLE_W = ANGLE_BITS
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_lanes               o_lanes
);

    // shift that puts one full turn of the angle at 2^32
    localparam int PH_SHIFT = PHASE_BITS - ANGLE_W;

    logic   r_valid;
    t_lanes r_lanes;
    t_lanes n_lanes;
    logic   w_adv;

    // stage advances when empty or when the next stage takes its content
    assign w_adv   = ~r_valid | i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

    // phase from angle, fold second and third quarter by a half turn
    always_comb begin
        logic [PHASE_BITS-1:0] ph;
        logic                  fl;
        n_lanes = r_lanes;
        for (int k = 0; k < EUL_LANES; k++) begin
            ph = 32'($signed(i_data[k*FIELD_W +: FIELD_W])) << PH_SHIFT;
            fl = ph[PHASE_BITS-1] ^ ph[PHASE_BITS-2];
            n_lanes[k].x    = CORDIC_X0;
            n_lanes[k].y    = '0;
            n_lanes[k].z    = $signed({ph[PHASE_BITS-1] ^ fl, ph[PHASE_BITS-2:0]});
            n_lanes[k].flip = fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_lanes <= n_lanes;
        end
    end

endmodule

@@ hw/rtl/eul_cordic_cell.sv @@
// one cordic rotation step for all three angle lanes, registered
module eul_cordic_cell
    import eul_pkg::*;
#(
    parameter int STEP = 0
)(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_lanes i_lanes,
    output logic   o_valid,
    input  logic   i_ready,
    output t_lanes o_lanes
);

    logic   r_valid;
    t_lanes r_lanes;
    t_lanes n_lanes;
    logic   w_adv;

    assign w_adv   = ~r_valid | i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

    // rotate toward zero residual phase, floor shifts
    always_comb begin
        for (int k = 0; k < EUL_LANES; k++) begin
            if (!i_lanes[k].z[DW-1]) begin
                n_lanes[k].x = i_lanes[k].x - (i_lanes[k].y >>> STEP);
                n_lanes[k].y = i_lanes[k].y + (i_lanes[k].x >>> STEP);
                n_lanes[k].z = i_lanes[k].z - ATAN_TURNS[STEP];
            end else begin
                n_lanes[k].x = i_lanes[k].x + (i_lanes[k].y >>> STEP);
                n_lanes[k].y = i_lanes[k].y - (i_lanes[k].x >>> STEP);
                n_lanes[k].z = i_lanes[k].z + ATAN_TURNS[STEP];
            end
            n_lanes[k].flip = i_lanes[k].flip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_lanes <= n_lanes;
        end
    end

endmodule

@@ hw/rtl/eul_unfold.sv @@
// undoes the half-turn fold and registers sine and cosine of each angle
module eul_unfold
    import eul_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_lanes i_lanes,
    output logic   o_valid,
    input  logic   i_ready,
    output t_trigs o_trigs
);

    logic   r_valid;
    t_trigs r_trigs;
    t_trigs n_trigs;
    logic   w_adv;

    assign w_adv   = ~r_valid | i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_trigs = r_trigs;

    // negate both outputs for folded angles
    always_comb begin
        for (int k = 0; k < EUL_LANES; k++) begin
            n_trigs[k].cos = i_lanes[k].flip ? -i_lanes[k].x : i_lanes[k].x;
            n_trigs[k].sin = i_lanes[k].flip ? -i_lanes[k].y : i_lanes[k].y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_trigs <= n_trigs;
        end
    end

endmodule

@@ hw/rtl/eul_matrix.sv @@
// products, sums and quantizing of the nine matrix entries, five registered stages
module eul_matrix
    import eul_pkg::*;
#(
    parameter int FRAC_W = FRAC_BITS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_trigs                i_trigs,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_adv;
    logic [NSTG-1:0] w_in_vld;

    // stage 1: raw q60 products
    logic signed [2*DW-1:0] r_p_cysp, r_p_sysp, r_p_cycp, r_p_sycr, r_p_sysr;
    logic signed [2*DW-1:0] r_p_sycp, r_p_cycr, r_p_cysr, r_p_cpsr, r_p_cpcr;
    logic signed [DW-1:0]   r1_sr, r1_cr, r1_sp;

    // stage 2: rounded products
    logic signed [DW-1:0] r_xsp, r_ysp, r_cycp, r_sycr, r_sysr;
    logic signed [DW-1:0] r_sycp, r_cycr, r_cysr, r_cpsr, r_cpcr;
    logic signed [DW-1:0] r2_sr, r2_cr, r2_sp;

    // stage 3: second-level products
    logic signed [2*DW-1:0] r_q_xsr, r_q_xcr, r_q_ysr, r_q_ycr;
    logic signed [DW-1:0]   r3_cycp, r3_sycr, r3_sysr, r3_sycp, r3_cycr;
    logic signed [DW-1:0]   r3_cysr, r3_cpsr, r3_cpcr, r3_sp;

    // stage 4: entry sums in q30, stage 5: quantized entries
    logic signed [DW:0]        r_sum [OUT_FIELDS];
    logic [OUT_DATA_W-1:0]     r_out;

    logic signed [DW-1:0] w_sr, w_cr, w_sp, w_cp, w_sy, w_cy;

    assign w_sr = i_trigs[LANE_ROLL].sin;
    assign w_cr = i_trigs[LANE_ROLL].cos;
    assign w_sp = i_trigs[LANE_PITCH].sin;
    assign w_cp = i_trigs[LANE_PITCH].cos;
    assign w_sy = i_trigs[LANE_YAW].sin;
    assign w_cy = i_trigs[LANE_YAW].cos;

    // ready chain: a stage moves when empty or when the next one moves
    always_comb begin
        w_adv[NSTG-1] = ~r_vld[NSTG-1] | i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end
        w_in_vld[0] = i_valid;
        for (int k = 1; k < NSTG; k++) begin
            w_in_vld[k] = r_vld[k-1];
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= w_in_vld[k];
                end
            end
        end
    end

    // stage 1 products
    always_ff @(posedge i_clk) begin
        if (w_adv[0] && w_in_vld[0]) begin
            r_p_cysp <= w_cy * w_sp;
            r_p_sysp <= w_sy * w_sp;
            r_p_cycp <= w_cy * w_cp;
            r_p_sycr <= w_sy * w_cr;
            r_p_sysr <= w_sy * w_sr;
            r_p_sycp <= w_sy * w_cp;
            r_p_cycr <= w_cy * w_cr;
            r_p_cysr <= w_cy * w_sr;
            r_p_cpsr <= w_cp * w_sr;
            r_p_cpcr <= w_cp * w_cr;
            r1_sr    <= w_sr;
            r1_cr    <= w_cr;
            r1_sp    <= w_sp;
        end
    end

    // stage 2 rounding
    always_ff @(posedge i_clk) begin
        if (w_adv[1] && w_in_vld[1]) begin
            r_xsp  <= eul_rnd_q30(r_p_cysp);
            r_ysp  <= eul_rnd_q30(r_p_sysp);
            r_cycp <= eul_rnd_q30(r_p_cycp);
            r_sycr <= eul_rnd_q30(r_p_sycr);
            r_sysr <= eul_rnd_q30(r_p_sysr);
            r_sycp <= eul_rnd_q30(r_p_sycp);
            r_cycr <= eul_rnd_q30(r_p_cycr);
            r_cysr <= eul_rnd_q30(r_p_cysr);
            r_cpsr <= eul_rnd_q30(r_p_cpsr);
            r_cpcr <= eul_rnd_q30(r_p_cpcr);
            r2_sr  <= r1_sr;
            r2_cr  <= r1_cr;
            r2_sp  <= r1_sp;
        end
    end

    // stage 3 products with the roll terms
    always_ff @(posedge i_clk) begin
        if (w_adv[2] && w_in_vld[2]) begin
            r_q_xsr <= r_xsp * r2_sr;
            r_q_xcr <= r_xsp * r2_cr;
            r_q_ysr <= r_ysp * r2_sr;
            r_q_ycr <= r_ysp * r2_cr;
            r3_cycp <= r_cycp;
            r3_sycr <= r_sycr;
            r3_sysr <= r_sysr;
            r3_sycp <= r_sycp;
            r3_cycr <= r_cycr;
            r3_cysr <= r_cysr;
            r3_cpsr <= r_cpsr;
            r3_cpcr <= r_cpcr;
            r3_sp   <= r2_sp;
        end
    end

    // stage 4 entry sums
    always_ff @(posedge i_clk) begin
        if (w_adv[3] && w_in_vld[3]) begin
            r_sum[0] <= 33'(r3_cycp);
            r_sum[1] <= 33'(eul_rnd_q30(r_q_xsr)) - 33'(r3_sycr);
            r_sum[2] <= 33'(eul_rnd_q30(r_q_xcr)) + 33'(r3_sysr);
            r_sum[3] <= 33'(r3_sycp);
            r_sum[4] <= 33'(eul_rnd_q30(r_q_ysr)) + 33'(r3_cycr);
            r_sum[5] <= 33'(eul_rnd_q30(r_q_ycr)) - 33'(r3_cysr);
            r_sum[6] <= -33'(r3_sp);
            r_sum[7] <= 33'(r3_cpsr);
            r_sum[8] <= 33'(r3_cpcr);
        end
    end

    // stage 5 quantize into the output register
    always_ff @(posedge i_clk) begin
        if (w_adv[4] && w_in_vld[4]) begin
            for (int k = 0; k < OUT_FIELDS; k++) begin
                r_out[k*FIELD_W +: FIELD_W] <= eul_quant(r_sum[k], FRAC_W);
            end
        end
    end

endmodule

@@ hw/rtl/euler_to_rotation_matrix.sv @@
// top level: zyx euler angles to rotation matrix, fold stage, cordic cell chain, matrix stages
//
// Takes roll, pitch and yaw as signed 16-bit binary angles (65536 is one turn) and returns
// the nine entries of R = Rz(yaw) * Ry(pitch) * Rx(roll) in signed Q1.14, rounded to
// nearest with ties away from zero and clamped to +-16384. ANGLE_W sets the number of
// angle bits that make one turn and FRAC_W the fraction bits of the entries. One transfer
// is taken every cycle unless a stall on the output has filled the pipeline. There are 37
// register stages: one fold stage, a chain of 30 cordic cells that work on all three
// angles side by side, one unfold stage and five product, sum and quantize stages. Every
// stage has its own valid bit, so a stall on the output holds only the stages that are
// full and the input keeps taking transfers until the pipeline is full. The block holds
// no state beyond the pipeline.
module euler_to_rotation_matrix
    import eul_pkg::*;
#(
    parameter int ANGLE_W = ANGLE_BITS,
    parameter int FRAC_W  = FRAC_BITS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // rot_00 [15:0], rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21,
    // rot_22 [143:128]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_lanes w_lanes [CORDIC_STEPS+1];
    logic   w_valid [CORDIC_STEPS+1];
    logic   w_ready [CORDIC_STEPS+1];

    t_trigs w_trigs;
    logic   w_trig_valid;
    logic   w_trig_ready;

    // fold the angles into the first and fourth quarter
    eul_fold #(
        .ANGLE_W (ANGLE_W)
    ) u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_lanes (w_lanes[0])
    );

    // cordic chain, one step per cell
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        eul_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_lanes (w_lanes[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_lanes (w_lanes[g+1])
        );
    end

    // sine and cosine with the fold undone
    eul_unfold u_unfold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[CORDIC_STEPS]),
        .o_ready (w_ready[CORDIC_STEPS]),
        .i_lanes (w_lanes[CORDIC_STEPS]),
        .o_valid (w_trig_valid),
        .i_ready (w_trig_ready),
        .o_trigs (w_trigs)
    );

    // matrix entries into the output register
    eul_matrix #(
        .FRAC_W (FRAC_W)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_trig_valid),
        .o_ready (w_trig_ready),
        .i_trigs (w_trigs),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule
